@@ src/esc_pkg.sv @@
// Shared types and constants for the epoch-seconds to calendar converter.
// Holds the field widths, pipeline depth and the fixed-point reciprocals
// used by the constant divisions that are not by a power of two. No dependencies.
package esc_pkg;

    localparam int STAGES = 7;

    localparam int SECS_W      = 32;
    localparam int DAY_W       = 5;
    localparam int MON_W       = 4;
    localparam int YRS_W       = 8;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = DAY_W + MON_W + YRS_W + HOUR_W + MIN_W + SEC_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int DAYS_W     = 16;
    localparam int REM_DAY_W  = 17;
    localparam int REM_HOUR_W = 12;
    localparam int JA_W       = 22;
    localparam int JC_W       = 7;
    localparam int JA2_W      = 16;
    localparam int JY_W       = 8;
    localparam int JA3_W      = 10;
    localparam int JM_W       = 6;

    localparam logic [63:0] SECS_PER_DAY  = 64'd86400;
    localparam logic [63:0] SECS_PER_HOUR = 64'd3600;
    localparam logic [63:0] SECS_PER_MIN  = 64'd60;
    localparam logic [63:0] JD_BIAS       = 64'd68569;
    localparam logic [63:0] JDN_OF_EPOCH  = 64'd2440588;
    localparam logic [63:0] JD_OFFSET     = JD_BIAS + JDN_OF_EPOCH;
    localparam logic [63:0] DAYS_PER_400Y = 64'd146097;
    localparam logic [63:0] YEAR_SCALE    = 64'd4000;
    localparam logic [63:0] YEAR_DIV      = 64'd1461001;
    localparam logic [63:0] DAYS_PER_4Y   = 64'd1461;
    localparam logic [63:0] MONTH_BIAS    = 64'd31;
    localparam logic [63:0] MONTH_SCALE   = 64'd80;
    localparam logic [63:0] MONTH_DIV     = 64'd2447;
    localparam logic [63:0] MONTH_WRAP    = 64'd11;
    localparam logic [63:0] MONTHS        = 64'd12;
    localparam logic [63:0] BASE_YEAR     = 64'd1970;
    localparam logic [63:0] CENTURY_BIAS  = 64'd49;
    localparam logic [63:0] YEAR_OFFSET   = 64'd100 * CENTURY_BIAS + BASE_YEAR;

    // Exact quotients: floor(x/d) = (x * ceil(2^(N+l)/d)) >> (N+l) for N-bit x.
    localparam int          DAY_PRE   = 7;
    localparam logic [63:0] DAY_ODD   = SECS_PER_DAY >> DAY_PRE;
    localparam int          DAY_SHIFT = 35;
    localparam int          DAY_PW    = DAY_SHIFT + DAYS_W;
    localparam logic [63:0] DAY_RECIP = ((64'd1 << DAY_SHIFT) + DAY_ODD - 64'd1) / DAY_ODD;

    localparam int          C_SHIFT = 42;
    localparam int          C_PW    = C_SHIFT + JC_W;
    localparam logic [63:0] C_RECIP =
        64'd4 * (((64'd1 << C_SHIFT) + DAYS_PER_400Y - 64'd1) / DAYS_PER_400Y);

    localparam int          Y_SHIFT = 49;
    localparam int          Y_PW    = Y_SHIFT + JY_W;
    localparam logic [63:0] Y_RECIP =
        YEAR_SCALE * (((64'd1 << Y_SHIFT) + YEAR_DIV - 64'd1) / YEAR_DIV);

    localparam int          M_SHIFT = 29;
    localparam int          M_PW    = M_SHIFT + JM_W;
    localparam logic [63:0] M_RECIP =
        MONTH_SCALE * (((64'd1 << M_SHIFT) + MONTH_DIV - 64'd1) / MONTH_DIV);

    localparam int          D_SHIFT = 25;
    localparam int          D_QW    = 11;
    localparam int          D_PW    = D_SHIFT + D_QW;
    localparam logic [63:0] D_RECIP =
        MONTH_DIV * (((64'd1 << D_SHIFT) + MONTH_SCALE - 64'd1) / MONTH_SCALE);

    localparam int          HOUR_SHIFT = 29;
    localparam int          HOUR_PW    = HOUR_SHIFT + 6;
    localparam logic [63:0] HOUR_RECIP =
        ((64'd1 << HOUR_SHIFT) + SECS_PER_HOUR - 64'd1) / SECS_PER_HOUR;

    localparam int          MIN_SHIFT = 18;
    localparam int          MIN_PW    = MIN_SHIFT + 7;
    localparam logic [63:0] MIN_RECIP =
        ((64'd1 << MIN_SHIFT) + SECS_PER_MIN - 64'd1) / SECS_PER_MIN;

    typedef logic [STAGES-1:0] stage_vec_t;

    typedef struct packed {
        logic [YRS_W-1:0] years;
        logic [MON_W-1:0] month;
        logic [DAY_W-1:0] day;
    } date_t;

    typedef struct packed {
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
    } tod_t;

endpackage

@@ src/epoch_seconds_to_calendar.sv @@
// Top level of the epoch-seconds to calendar converter: stream ports, the
// day-count stage and the pipeline valid/ready control. Uses esc_pkg,
// esc_tod and esc_date.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         32     epoch_seconds
//  m_axis    out        40     day, month, years, hour, minute, second
//
// Each pipeline stage ends in a register; one transaction can be accepted
// in every cycle in which the pipeline is not held full by an m_axis stall.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall on m_axis holds the full stages in place, while empty stages keep
// filling, so s_axis_tready drops only when all seven stages hold data.
module epoch_seconds_to_calendar (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [esc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] epoch_seconds
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] day_of_month, [8:5] month_index, [16:9] years_since_1970,
    // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute
    output logic [esc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int NS  = esc_pkg::STAGES;
    localparam int DPW = esc_pkg::DAY_PW;
    localparam int DYW = esc_pkg::DAYS_W;
    localparam int SW  = esc_pkg::SECS_W;

    esc_pkg::stage_vec_t valid_reg, valid_next, adv;
    logic [SW-1:0]       secs_s1_reg;
    logic [DYW-1:0]      days_s1_reg, days_next;
    logic [DPW-1:0]      day_prod;
    esc_pkg::date_t      date;
    esc_pkg::tod_t       tod;

    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || m_axis_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? s_axis_tvalid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign day_prod  = DPW'(s_axis_tdata[SW-1:esc_pkg::DAY_PRE]) * DPW'(esc_pkg::DAY_RECIP);
    assign days_next = day_prod[esc_pkg::DAY_SHIFT +: DYW];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            secs_s1_reg <= s_axis_tdata[SW-1:0];
            days_s1_reg <= days_next;
        end
    end

    esc_tod u_tod (
        .clk  (clk),
        .adv  (adv),
        .secs (secs_s1_reg),
        .days (days_s1_reg),
        .tod  (tod)
    );

    esc_date u_date (
        .clk  (clk),
        .adv  (adv),
        .days (days_s1_reg),
        .date (date)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[NS-1];
    assign m_axis_tdata  = {{esc_pkg::OUT_PAD_W{1'b0}}, tod.second, tod.minute, tod.hour,
                            date.years, date.month, date.day};

endmodule

@@ src/esc_tod.sv @@
// Time-of-day datapath: splits the seconds left over within the day into
// hour, minute and second over pipeline stages two to seven. Uses esc_pkg.
module esc_tod (
    input  logic                          clk,
    input  esc_pkg::stage_vec_t           adv,
    input  logic [esc_pkg::SECS_W-1:0]    secs,
    input  logic [esc_pkg::DAYS_W-1:0]    days,
    output esc_pkg::tod_t                 tod
);

    localparam int RDW = esc_pkg::REM_DAY_W;
    localparam int RHW = esc_pkg::REM_HOUR_W;
    localparam int HW  = esc_pkg::HOUR_W;
    localparam int MW  = esc_pkg::MIN_W;
    localparam int SW  = esc_pkg::SEC_W;
    localparam int SCW = esc_pkg::SECS_W;
    localparam int HPW = esc_pkg::HOUR_PW;
    localparam int MPW = esc_pkg::MIN_PW;

    logic [RDW-1:0] rem_s2_reg, rem_s3_reg, rem_s2_next;
    logic [HW-1:0]  hour_s3_reg, hour_s4_reg, hour_s5_reg, hour_s6_reg, hour_s7_reg;
    logic [HW-1:0]  hour_s3_next;
    logic [RHW-1:0] rem2_s4_reg, rem2_s5_reg, rem2_s4_next;
    logic [MW-1:0]  min_s5_reg, min_s6_reg, min_s7_reg, min_s5_next;
    logic [SW-1:0]  sec_s6_reg, sec_s7_reg, sec_s6_next;
    logic [HPW-1:0] hour_prod;
    logic [MPW-1:0] min_prod;

    assign rem_s2_next  = RDW'(secs - SCW'(days) * SCW'(esc_pkg::SECS_PER_DAY));
    assign hour_prod    = HPW'(rem_s2_reg) * HPW'(esc_pkg::HOUR_RECIP);
    assign hour_s3_next = hour_prod[esc_pkg::HOUR_SHIFT +: HW];
    assign rem2_s4_next = RHW'(rem_s3_reg - RDW'(hour_s3_reg) * RDW'(esc_pkg::SECS_PER_HOUR));
    assign min_prod     = MPW'(rem2_s4_reg) * MPW'(esc_pkg::MIN_RECIP);
    assign min_s5_next  = min_prod[esc_pkg::MIN_SHIFT +: MW];
    assign sec_s6_next  = SW'(rem2_s5_reg - RHW'(min_s5_reg) * RHW'(esc_pkg::SECS_PER_MIN));

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            rem_s2_reg <= rem_s2_next;
        end
        if (adv[2])
        begin
            rem_s3_reg  <= rem_s2_reg;
            hour_s3_reg <= hour_s3_next;
        end
        if (adv[3])
        begin
            rem2_s4_reg <= rem2_s4_next;
            hour_s4_reg <= hour_s3_reg;
        end
        if (adv[4])
        begin
            rem2_s5_reg <= rem2_s4_reg;
            min_s5_reg  <= min_s5_next;
            hour_s5_reg <= hour_s4_reg;
        end
        if (adv[5])
        begin
            sec_s6_reg  <= sec_s6_next;
            min_s6_reg  <= min_s5_reg;
            hour_s6_reg <= hour_s5_reg;
        end
        if (adv[6])
        begin
            sec_s7_reg  <= sec_s6_reg;
            min_s7_reg  <= min_s6_reg;
            hour_s7_reg <= hour_s6_reg;
        end
    end

    assign tod.hour   = hour_s7_reg;
    assign tod.minute = min_s7_reg;
    assign tod.second = sec_s7_reg;

endmodule

@@ src/esc_date.sv @@
// Date datapath: integer Julian-day to Gregorian conversion of the day count,
// one or two constant multiplies per stage over stages two to seven. Uses esc_pkg.
module esc_date (
    input  logic                          clk,
    input  esc_pkg::stage_vec_t           adv,
    input  logic [esc_pkg::DAYS_W-1:0]    days,
    output esc_pkg::date_t                date
);

    localparam int AW   = esc_pkg::JA_W;
    localparam int CW   = esc_pkg::JC_W;
    localparam int A2W  = esc_pkg::JA2_W;
    localparam int YW   = esc_pkg::JY_W;
    localparam int A3W  = esc_pkg::JA3_W;
    localparam int MW   = esc_pkg::JM_W;
    localparam int CPW  = esc_pkg::C_PW;
    localparam int YPW  = esc_pkg::Y_PW;
    localparam int MPW  = esc_pkg::M_PW;
    localparam int DPW  = esc_pkg::D_PW;
    localparam int DQW  = esc_pkg::D_QW;
    localparam int T2W  = 25;
    localparam int T3W  = 19;
    localparam int YBW  = 16;
    localparam int DW   = esc_pkg::DAY_W;
    localparam int MONW = esc_pkg::MON_W;
    localparam int YRW  = esc_pkg::YRS_W;

    logic [AW-1:0]  a_next, a_s2_reg;
    logic [CPW-1:0] c_prod;
    logic [CW-1:0]  c_s2_reg, c_s3_reg, c_s4_reg, c_s5_reg;
    logic [T2W-1:0] c_term;
    logic [A2W-1:0] a2_next, a2_s3_reg, a2_s4_reg;
    logic [YPW-1:0] y_prod;
    logic [YW-1:0]  y_s4_reg, y_s5_reg;
    logic [A3W-1:0] a3_next, a3_s5_reg, a3_s6_reg;
    logic [MPW-1:0] m_prod;
    logic [MW-1:0]  m_s6_reg;
    logic [YBW-1:0] ybase_full;
    logic [YRW-1:0] ybase_s6_reg;
    logic [DPW-1:0] d_prod;
    logic [DQW-1:0] d_sub;
    logic           wrap;
    logic [MW-1:0]  mon_full;
    logic [DW-1:0]  day_next, day_reg;
    logic [MONW-1:0] mon_next, mon_reg;
    logic [YRW-1:0] yrs_next, yrs_reg;

    assign a_next  = AW'(esc_pkg::DAYS_W'(days) + AW'(esc_pkg::JD_OFFSET));
    assign c_prod  = CPW'(a_next) * CPW'(esc_pkg::C_RECIP);

    assign c_term  = (T2W'(c_s2_reg) * T2W'(esc_pkg::DAYS_PER_400Y) + T2W'(3)) >> 2;
    assign a2_next = A2W'(T2W'(a_s2_reg) - c_term);

    assign y_prod  = (YPW'(a2_s3_reg) + YPW'(1)) * YPW'(esc_pkg::Y_RECIP);

    assign a3_next = A3W'(T3W'(a2_s4_reg)
                          - ((T3W'(y_s4_reg) * T3W'(esc_pkg::DAYS_PER_4Y)) >> 2)
                          + T3W'(esc_pkg::MONTH_BIAS));

    assign m_prod     = MPW'(a3_s5_reg) * MPW'(esc_pkg::M_RECIP);
    assign ybase_full = YBW'(c_s5_reg) * YBW'(100) + YBW'(y_s5_reg)
                        - YBW'(esc_pkg::YEAR_OFFSET);

    assign d_prod   = DPW'(m_s6_reg) * DPW'(esc_pkg::D_RECIP);
    assign d_sub    = d_prod[esc_pkg::D_SHIFT +: DQW];
    assign day_next = DW'(DQW'(a3_s6_reg) - d_sub);
    assign wrap     = (m_s6_reg >= MW'(esc_pkg::MONTH_WRAP));
    assign mon_full = m_s6_reg + MW'(1) - (wrap ? MW'(esc_pkg::MONTHS) : MW'(0));
    assign mon_next = mon_full[MONW-1:0];
    assign yrs_next = ybase_s6_reg + YRW'(wrap);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            a_s2_reg <= a_next;
            c_s2_reg <= c_prod[esc_pkg::C_SHIFT +: CW];
        end
        if (adv[2])
        begin
            a2_s3_reg <= a2_next;
            c_s3_reg  <= c_s2_reg;
        end
        if (adv[3])
        begin
            y_s4_reg  <= y_prod[esc_pkg::Y_SHIFT +: YW];
            a2_s4_reg <= a2_s3_reg;
            c_s4_reg  <= c_s3_reg;
        end
        if (adv[4])
        begin
            a3_s5_reg <= a3_next;
            y_s5_reg  <= y_s4_reg;
            c_s5_reg  <= c_s4_reg;
        end
        if (adv[5])
        begin
            m_s6_reg     <= m_prod[esc_pkg::M_SHIFT +: MW];
            a3_s6_reg    <= a3_s5_reg;
            ybase_s6_reg <= ybase_full[YRW-1:0];
        end
        if (adv[6])
        begin
            day_reg <= day_next;
            mon_reg <= mon_next;
            yrs_reg <= yrs_next;
        end
    end

    assign date.day   = day_reg;
    assign date.month = mon_reg;
    assign date.years = yrs_reg;

endmodule

@@ src/esc_checker.sv @@
// Port-level checker for the epoch-seconds to calendar converter, with the
// bind that attaches it to the top level. Uses esc_pkg for port widths.
module esc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [esc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // A stalled result must hold its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input backpressure only comes from a full pipeline behind a stalled output.
    a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // Each delivered time field and the month lie in range, the day is nonzero and the pad is zero.
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] <= 4'd11
            && m_axis_tdata[21:17] <= 5'd23 && m_axis_tdata[27:22] <= 6'd59
            && m_axis_tdata[33:28] <= 6'd59 && m_axis_tdata[39:34] == 6'd0)
        else $error("result field out of range");

    // With the output never stalled, an accepted transaction appears on m_axis once it has passed through the pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
